// ----- rtl/sps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the speaker posterior segmenter.
// No dependencies; imported by every module of the block.
package sps_pkg;

  localparam int NUM_LANES = 4;
  localparam int POST_W    = 16;
  localparam int DUR_W     = 24;
  localparam int SPK_W     = 3;
  localparam int TIME_W    = 32;
  localparam int FRAME_W   = 24;
  localparam int LANE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEAKERS     = 2'd2;

  localparam logic [POST_W-1:0] THRESHOLD_RST    = 16'd16384;
  localparam logic [DUR_W-1:0]  MAX_DURATION_RST = 24'd20000;
  localparam logic [SPK_W-1:0]  SPEAKERS_RST     = 3'd3;

  // event kinds on the result channel
  localparam logic EV_START = 1'b0;
  localparam logic EV_STOP  = 1'b1;

  // per-lane outcome of one frame
  localparam logic [1:0] LC_NONE  = 2'd0;  // no event
  localparam logic [1:0] LC_START = 2'd1;  // start at frame time
  localparam logic [1:0] LC_STOP  = 2'd2;  // stop at frame time
  localparam logic [1:0] LC_SPLIT = 2'd3;  // stop+start at split, stop at frame time

  localparam logic [1:0] SPLIT_LAST_SUB = 2'd2;

  typedef struct packed {
    logic              restart;
    logic [POST_W-1:0] posterior_0;
    logic [POST_W-1:0] posterior_1;
    logic [POST_W-1:0] posterior_2;
    logic [POST_W-1:0] posterior_3;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] speaker;
    logic              event_kind;
    logic [TIME_W-1:0] event_time_ms;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        code;
    logic [TIME_W-1:0] split_ms;
    logic              active_nxt;
    logic [TIME_W-1:0] start_nxt;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][1:0]        codes;
    logic [NUM_LANES-1:0][TIME_W-1:0] split_ms;
    logic [TIME_W-1:0]                t_ms;
  } frame_evt_t;

  typedef struct packed {
    logic busy;      // events of a frame still waiting in the buffer
    logic can_load;  // buffer is free for the next frame this cycle
  } mrg_stat_t;

endpackage

// ----- rtl/speaker_posterior_segmenter.sv -----
`timescale 1ns / 1ps
// Speaker posterior segmenter: per-frame speaker posteriors in, segment
// start/stop items out. Top level; depends on sps_pkg, sps_frame_clock,
// sps_lane and sps_merge.
//
// Input channel (in_valid/in_stall/in_item): one frame of up to four Q1.15
// posteriors plus a restart flag. Result channel (out_valid/out_stall/
// out_item): one start or stop event per item, lane order, last set on the
// final event of a frame. A frame with no event produces nothing.
// Configuration (cfg_we/cfg_index/cfg_wdata): threshold, max segment length,
// lanes in use; write only while the block is idle.
// All lanes decide in the cycle a frame is accepted; the merge stage then
// sends one event per cycle unless out_stall holds it. A frame's outcomes
// are registered in the merge buffer and then, one by one, in the output
// register. A frame has at most 12 events; the next frame is taken in the
// cycle the last event of the previous one enters the output register.
// Reset (rst_n low, synchronous) restores register defaults, clears the frame
// counter and all speaker activity. When out_stall is high the output item
// holds, the buffer holds, and in_stall rises once the buffer is occupied.
module speaker_posterior_segmenter import sps_pkg::*; #(
  parameter int AUDIO_RATE_HZ = 16000,
  parameter int MAX_SPEAKERS  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic [SPK_W-1:0] MAX_SPK_V = SPK_W'(MAX_SPEAKERS);

  logic [POST_W-1:0] thr_r;
  logic [DUR_W-1:0]  maxdur_r;
  logic [SPK_W-1:0]  spk_r, lanes_used;

  logic [NUM_LANES-1:0]              active_r;
  logic [NUM_LANES-1:0][TIME_W-1:0]  start_r;
  logic [NUM_LANES-1:0][POST_W-1:0]  post;
  lane_res_t                         res [NUM_LANES];
  logic [NUM_LANES-1:0]              act_in;

  logic              accept, ev_any;
  logic [TIME_W-1:0] t_ms;
  frame_evt_t        evt;
  mrg_stat_t         mstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      maxdur_r <= MAX_DURATION_RST;
      spk_r    <= SPEAKERS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    thr_r    <= cfg_wdata[POST_W-1:0];
        CFG_MAX_DURATION: maxdur_r <= cfg_wdata[DUR_W-1:0];
        CFG_SPEAKERS:     spk_r    <= cfg_wdata[SPK_W-1:0];
        default: ;
      endcase
    end
  end

  assign lanes_used = (spk_r > MAX_SPK_V) ? MAX_SPK_V : spk_r;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = !mstat.can_load;

  assign post[0] = in_item.posterior_0;
  assign post[1] = in_item.posterior_1;
  assign post[2] = in_item.posterior_2;
  assign post[3] = in_item.posterior_3;

  sps_frame_clock #(
    .AUDIO_RATE_HZ(AUDIO_RATE_HZ)
  ) u_clock (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(accept),
    .restart(in_item.restart),
    .t_ms   (t_ms)
  );

  assign act_in = in_item.restart ? '0 : active_r;

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    if (j < MAX_SPEAKERS) begin : g_on
      sps_lane u_lane (
        .en             (SPK_W'(j) < lanes_used),
        .posterior      (post[j]),
        .threshold      (thr_r),
        .max_duration_ms(maxdur_r),
        .active         (act_in[j]),
        .start_ms       (start_r[j]),
        .t_ms           (t_ms),
        .res            (res[j])
      );
    end else begin : g_off
      assign res[j].code       = LC_NONE;
      assign res[j].split_ms   = start_r[j];
      assign res[j].active_nxt = act_in[j];
      assign res[j].start_nxt  = start_r[j];
    end

    assign evt.codes[j]    = res[j].code;
    assign evt.split_ms[j] = res[j].split_ms;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        active_r[j] <= 1'b0;
      end else if (accept) begin
        active_r[j] <= res[j].active_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (accept) start_r[j] <= res[j].start_nxt;
    end
  end

  assign evt.t_ms = t_ms;

  always_comb begin
    ev_any = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (evt.codes[i] != LC_NONE) ev_any = 1'b1;
    end
  end

  sps_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .evt      (evt),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .stat     (mstat)
  );

  // a frame with events keeps the merge buffer occupied afterwards
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_any |=> mstat.busy)
    else $error("frame events lost after acceptance");

  // an empty buffer never back-pressures the input
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !mstat.busy |-> !in_stall)
    else $error("input stalled with empty merge buffer");

  // a non-final event being delivered means the rest of its frame is buffered
  a_frame_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> mstat.busy)
    else $error("frame ended without last flag");

endmodule

// ----- rtl/sps_frame_clock.sv -----
`timescale 1ns / 1ps
// Frame counter and frame time in ms, kept as quotient and remainder
// so each frame step is one add and compare. Depends on sps_pkg.
module sps_frame_clock import sps_pkg::*; #(
  parameter int AUDIO_RATE_HZ = 16000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              restart,
  output logic [TIME_W-1:0] t_ms
);

  // t = floor(((f*270 + 721)*2000 + SR) / (2*SR))
  localparam longint DEN  = 2 * longint'(AUDIO_RATE_HZ);
  localparam longint STEP = 270 * 2000;
  localparam longint QS   = STEP / DEN;
  localparam longint RS   = STEP % DEN;
  localparam longint N0   = 721 * 2000 + longint'(AUDIO_RATE_HZ);
  localparam longint Q0   = N0 / DEN;
  localparam longint R0   = N0 % DEN;
  localparam int     RW   = $clog2(DEN);

  localparam logic [TIME_W-1:0] Q0_V  = TIME_W'(Q0);
  localparam logic [TIME_W-1:0] QS_V  = TIME_W'(QS);
  localparam logic [RW-1:0]     R0_V  = RW'(R0);
  localparam logic [RW:0]       RS_V  = (RW+1)'(RS);
  localparam logic [RW:0]       DEN_V = (RW+1)'(DEN);

  logic [FRAME_W-1:0] fidx_r, fidx_nxt, base_f;
  logic [TIME_W-1:0]  q_r, q_nxt, base_q;
  logic [RW-1:0]      rem_r, rem_nxt, base_r;
  logic [RW:0]        rsum;

  always_comb begin
    base_f = restart ? '0 : fidx_r;
    base_q = restart ? Q0_V : q_r;
    base_r = restart ? R0_V : rem_r;
    rsum   = {1'b0, base_r} + RS_V;
    if (base_f == '1) begin
      // counter wraps, time starts over
      fidx_nxt = '0;
      q_nxt    = Q0_V;
      rem_nxt  = R0_V;
    end else if (rsum >= DEN_V) begin
      fidx_nxt = base_f + 1'b1;
      q_nxt    = base_q + QS_V + 1'b1;
      rem_nxt  = RW'(rsum - DEN_V);
    end else begin
      fidx_nxt = base_f + 1'b1;
      q_nxt    = base_q + QS_V;
      rem_nxt  = rsum[RW-1:0];
    end
  end

  assign t_ms = base_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fidx_r <= '0;
      q_r    <= Q0_V;
      rem_r  <= R0_V;
    end else if (advance) begin
      fidx_r <= fidx_nxt;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ----- rtl/sps_lane.sv -----
`timescale 1ns / 1ps
// One speaker lane: threshold compare, split point and segment decision.
// Depends on sps_pkg.
module sps_lane import sps_pkg::*; (
  input  logic              en,
  input  logic [POST_W-1:0] posterior,
  input  logic [POST_W-1:0] threshold,
  input  logic [DUR_W-1:0]  max_duration_ms,
  input  logic              active,
  input  logic [TIME_W-1:0] start_ms,
  input  logic [TIME_W-1:0] t_ms,
  output lane_res_t         res
);

  logic [TIME_W:0]   split_sum;
  logic [TIME_W-1:0] split_ms;

  always_comb begin
    split_sum = {1'b0, start_ms} + {{(TIME_W+1-DUR_W){1'b0}}, max_duration_ms};
    split_ms  = split_sum[TIME_W] ? '1 : split_sum[TIME_W-1:0];

    res.code       = LC_NONE;
    res.split_ms   = split_ms;
    res.active_nxt = active;
    res.start_nxt  = start_ms;
    if (en) begin
      if (posterior > threshold) begin
        if (!active) begin
          res.code       = LC_START;
          res.active_nxt = 1'b1;
          res.start_nxt  = t_ms;
        end
      end else if (active) begin
        res.active_nxt = 1'b0;
        if (t_ms > split_ms) begin
          res.code      = LC_SPLIT;
          res.start_nxt = split_ms;
        end else begin
          res.code = LC_STOP;
        end
      end
    end
  end

endmodule

// ----- rtl/sps_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: holds one frame's lane outcomes and serializes them,
// in lane order, into the output register. Depends on sps_pkg.
module sps_merge import sps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  frame_evt_t evt,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  output mrg_stat_t  stat
);

  logic [NUM_LANES-1:0] pend_r, pend_nxt, rest;
  logic [1:0]           sub_r, sub_nxt;
  frame_evt_t           evt_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [LANE_W-1:0] cur;
  logic [1:0]        cur_code;
  logic              last_sub, move;
  out_item_t         ev;

  always_comb begin
    cur = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (pend_r[i]) cur = LANE_W'(i);
    end
    cur_code = evt_r.codes[cur];
    rest     = pend_r & ~(NUM_LANES'(1) << cur);

    ev.speaker       = cur;
    ev.event_kind    = EV_STOP;
    ev.event_time_ms = evt_r.t_ms;
    last_sub         = 1'b1;
    case (cur_code)
      LC_SPLIT: begin
        last_sub = (sub_r == SPLIT_LAST_SUB);
        if (sub_r == 2'd0) begin
          ev.event_time_ms = evt_r.split_ms[cur];
        end else if (sub_r == 2'd1) begin
          ev.event_kind    = EV_START;
          ev.event_time_ms = evt_r.split_ms[cur];
        end
      end
      LC_START: ev.event_kind = EV_START;
      default:  ev.event_kind = EV_STOP;
    endcase
    ev.last = last_sub && (rest == '0);

    move = (pend_r != '0) && (!out_valid_r || !out_stall);

    pend_nxt = pend_r;
    sub_nxt  = sub_r;
    if (move) begin
      if (last_sub) begin
        pend_nxt = rest;
        sub_nxt  = '0;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
    if (load) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        pend_nxt[i] = (evt.codes[i] != LC_NONE);
      end
      sub_nxt = '0;
    end

    stat.busy     = (pend_r != '0);
    stat.can_load = (pend_r == '0) || (move && ev.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      sub_r  <= sub_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) evt_r <= evt;
    if (move) out_item_r <= ev;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- verif/speaker_posterior_segmenter_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for speaker_posterior_segmenter: directed frame table, then
// randomized segment traffic under several register settings. Needs sps_pkg and the RTL.
module speaker_posterior_segmenter_test;
  import sps_pkg::*;

  localparam longint AUDIO_HZ       = 16000;
  localparam longint FRAME_HOP      = 270;
  localparam longint FRAME_OFFSET   = 721;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     FRAMES_PER_PH  = 26;

  typedef struct packed {
    logic              hand;   // expectation typed into the table
    logic [3:0]        count;
    logic              kind;
    logic [TIME_W-1:0] ms;
  } frame_check_t;

  typedef enum {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    in_item_t             item;
    frame_check_t         chk;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  frame_check_t         in_check  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // segmenter state as the bench sees it
  logic [NUM_LANES-1:0] lane_open;
  logic [TIME_W-1:0]    lane_start [NUM_LANES];
  logic [FRAME_W-1:0]   frame_count;
  logic [POST_W-1:0]    thr_q15;
  logic [DUR_W-1:0]     seg_limit_ms;
  logic [SPK_W-1:0]     lane_count;

  out_item_t pending_events[$];
  stim_row_t stim_table[$];
  int        mismatches = 0;
  bit        sender_idle = 1'b1;
  bit        stall_on = 1'b1;
  int        stall_left = 0;

  speaker_posterior_segmenter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [TIME_W-1:0] frame_ms(logic [FRAME_W-1:0] f);
    logic [63:0] q;
    // round half up
    q = ((64'(f) * FRAME_HOP + FRAME_OFFSET) * 2000 + AUDIO_HZ) / (2 * AUDIO_HZ);
    return (q > 64'hFFFF_FFFF) ? '1 : q[TIME_W-1:0];
  endfunction

  function automatic out_item_t mk_event(int lane, logic kind, logic [TIME_W-1:0] ms);
    out_item_t e;
    e.speaker       = LANE_W'(lane);
    e.event_kind    = kind;
    e.event_time_ms = ms;
    e.last          = 1'b0;
    return e;
  endfunction

  // Works out the events of one accepted frame and queues them.
  function automatic void segment_frame(in_item_t it, frame_check_t chk);
    out_item_t         evs[$];
    logic [POST_W-1:0] post [NUM_LANES];
    logic [TIME_W-1:0] now;
    logic [TIME_W:0]   split;
    int                n_lanes;
    post[0] = it.posterior_0;
    post[1] = it.posterior_1;
    post[2] = it.posterior_2;
    post[3] = it.posterior_3;
    if (it.restart) begin
      frame_count = '0;
      lane_open   = '0;
    end
    n_lanes = (lane_count > NUM_LANES) ? NUM_LANES : int'(lane_count);
    now = frame_ms(frame_count);
    for (int j = 0; j < n_lanes; j++) begin
      if (post[j] > thr_q15) begin
        if (!lane_open[j]) begin
          evs.push_back(mk_event(j, EV_START, now));
          lane_open[j]  = 1'b1;
          lane_start[j] = now;
        end
      end else if (lane_open[j]) begin
        split = {1'b0, lane_start[j]} + seg_limit_ms;
        if (split[TIME_W]) split = {1'b0, {TIME_W{1'b1}}};
        if ({1'b0, now} > split) begin
          evs.push_back(mk_event(j, EV_STOP, split[TIME_W-1:0]));
          evs.push_back(mk_event(j, EV_START, split[TIME_W-1:0]));
          lane_start[j] = split[TIME_W-1:0];
        end
        evs.push_back(mk_event(j, EV_STOP, now));
        lane_open[j] = 1'b0;
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    frame_count = frame_count + 1'b1;
    if (chk.hand) begin
      evs.delete();
      for (int k = 0; k < chk.count; k++) begin
        evs.push_back(mk_event(k, chk.kind, chk.ms));
        if (k == chk.count - 1) evs[k].last = 1'b1;
      end
    end
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endfunction

  // prediction and checking, all on pre-edge values
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lane_open    = '0;
      frame_count  = '0;
      thr_q15      = THRESHOLD_RST;
      seg_limit_ms = MAX_DURATION_RST;
      lane_count   = SPEAKERS_RST;
      foreach (lane_start[j]) lane_start[j] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:    thr_q15      = cfg_wdata[POST_W-1:0];
          CFG_MAX_DURATION: seg_limit_ms = cfg_wdata[DUR_W-1:0];
          CFG_SPEAKERS:     lane_count   = cfg_wdata[SPK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) segment_frame(in_item, in_check);
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("unexpected item: speaker %0d kind %0d time %0d", out_item.speaker,
                 out_item.event_kind, out_item.event_time_ms);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (out_item.speaker !== want.speaker) begin
            $error("speaker: expected %0d, got %0d", want.speaker, out_item.speaker);
            mismatches++;
          end
          if (out_item.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, out_item.event_kind);
            mismatches++;
          end
          if (out_item.event_time_ms !== want.event_time_ms) begin
            $error("event_time_ms: expected %0d, got %0d", want.event_time_ms,
                   out_item.event_time_ms);
            mismatches++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item.last);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver back-pressure: mostly short bursts, now and then a long one
  always @(posedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(3, 0) == 0) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(15, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(2, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("speaker_posterior_segmenter regression: fail");
    $finish;
  end

  function automatic void add_frame_row(bit rs, int p0, int p1, int p2, int p3,
                                        int n, logic kind, int ms);
    stim_row_t r;
    r.kind              = ROW_FRAME;
    r.reg_idx           = CFG_THRESHOLD;
    r.reg_val           = '0;
    r.item.restart      = rs;
    r.item.posterior_0  = POST_W'(p0);
    r.item.posterior_1  = POST_W'(p1);
    r.item.posterior_2  = POST_W'(p2);
    r.item.posterior_3  = POST_W'(p3);
    r.chk.hand          = (n >= 0);
    r.chk.count         = (n >= 0) ? 4'(n) : 4'd0;
    r.chk.kind          = kind;
    r.chk.ms            = TIME_W'(ms);
    stim_table.push_back(r);
  endfunction

  function automatic void add_cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = CFG_DAT_W'(val);
    r.item    = '0;
    r.chk     = '0;
    stim_table.push_back(r);
  endfunction

  function automatic logic [POST_W-1:0] draw_post(bit hot, logic [POST_W-1:0] thr);
    int hi;
    if ($urandom_range(15, 0) == 0) return POST_W'($urandom);
    if (hot) begin
      if (thr == '1) return '1;
      if ($urandom_range(5, 0) == 0) return thr + 1'b1;
      hi = (thr < 32768) ? 32768 : 65535;
      return POST_W'($urandom_range(hi, int'(thr) + 1));
    end
    if ($urandom_range(5, 0) == 0) return thr;
    return POST_W'($urandom_range(int'(thr), 0));
  endfunction

  task automatic push_frame(in_item_t it, frame_check_t chk);
    int gap;
    in_item  <= it;
    in_check <= chk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = 0;
    if (sender_idle && $urandom_range(1, 0) == 0)
      gap = ($urandom_range(19, 0) == 0) ? $urandom_range(50, 20) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every expected item is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [POST_W-1:0] thr;
    logic [DUR_W-1:0]  dur;
    logic [SPK_W-1:0]  spk;
    logic [POST_W-1:0] post [NUM_LANES];
    bit                hot [NUM_LANES];
    in_item_t          it;

    // defaults: threshold 0.5, 20 s, three lanes; frame 0 is at 45 ms
    add_frame_row(0, 32768, 32768, 32768, 32768, 3, EV_START, 45);
    add_frame_row(0, 16384, 16384, 16384, 16384, 3, EV_STOP, 62);
    add_frame_row(0, 0, 0, 0, 0, 0, EV_START, 0);
    add_frame_row(0, 0, 0, 0, 65535, 0, EV_START, 0);       // lane 3 not in use
    add_frame_row(0, 16385, 65535, 0, 0, 2, EV_START, 113);
    add_frame_row(0, 0, 40000, 20000, 0, -1, EV_START, 0);
    add_frame_row(1, 32768, 32768, 32768, 32768, 3, EV_START, 45);
    add_cfg_row(CFG_MAX_DURATION, 0);
    add_frame_row(0, 0, 0, 0, 0, -1, EV_START, 0);           // split on all three lanes in use
    add_cfg_row(CFG_SPEAKERS, 7);                            // clamps to four lanes
    add_cfg_row(CFG_THRESHOLD, 0);
    add_frame_row(0, 1, 1, 1, 1, 4, EV_START, 79);
    add_frame_row(0, 0, 0, 0, 0, -1, EV_START, 0);           // twelve items
    add_cfg_row(CFG_SPEAKERS, 0);
    add_frame_row(0, 65535, 65535, 65535, 65535, 0, EV_START, 0);
    add_cfg_row(CFG_SPEAKERS, 4);
    add_cfg_row(CFG_THRESHOLD, 65535);
    add_frame_row(0, 65535, 65535, 65535, 65535, 0, EV_START, 0);
    add_cfg_row(CFG_THRESHOLD, 32768);
    add_cfg_row(CFG_MAX_DURATION, 24'hFF_FFFF);
    add_cfg_row(CFG_SPEAKERS, 5);
    add_frame_row(0, 32769, 32769, 32769, 32769, -1, EV_START, 0);
    add_frame_row(0, 32768, 32768, 32768, 32768, -1, EV_START, 0);
    add_cfg_row(CFG_SPEAKERS, 1);
    add_frame_row(1, 32769, 0, 0, 0, 1, EV_START, 45);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        settle();
        cfg_write(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        push_frame(stim_table[i].item, stim_table[i].chk);
      end
    end

    foreach (hot[j]) hot[j] = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin thr = 16'd16384; dur = 24'd120; spk = 3'd4; end
        1: begin
          thr = POST_W'($urandom_range(32768, 0));
          dur = DUR_W'($urandom_range(400, 0));
          spk = SPK_W'($urandom_range(4, 1));
        end
        2: begin thr = '0; dur = '0; spk = 3'd2; end
        3: begin thr = 16'd32768; dur = '1; spk = 3'd7; end
        4: begin
          thr = POST_W'($urandom_range(32768, 0));
          dur = DUR_W'($urandom);
          spk = 3'd5;
        end
        5: begin thr = 16'd40000; dur = 24'd60; spk = 3'd6; end
        6: begin
          thr = POST_W'($urandom_range(32768, 0));
          dur = DUR_W'($urandom_range(1000, 0));
          spk = 3'd1;
        end
        default: begin thr = THRESHOLD_RST; dur = MAX_DURATION_RST; spk = SPEAKERS_RST; end
      endcase
      cfg_write(CFG_THRESHOLD, CFG_DAT_W'(thr));
      cfg_write(CFG_MAX_DURATION, dur);
      cfg_write(CFG_SPEAKERS, CFG_DAT_W'(spk));
      sender_idle = (ph != 6);
      stall_on   <= (ph != 3);

      for (int k = 0; k < FRAMES_PER_PH; k++) begin
        if (ph == 1 && k == FRAMES_PER_PH / 2) settle();
        // lanes hold their activity for a few frames so segments grow long
        foreach (hot[j]) begin
          if ($urandom_range(4, 0) == 0) hot[j] = !hot[j];
          post[j] = draw_post(hot[j], thr);
        end
        it.restart     = ($urandom_range(29, 0) == 0);
        it.posterior_0 = post[0];
        it.posterior_1 = post[1];
        it.posterior_2 = post[2];
        it.posterior_3 = post[3];
        push_frame(it, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("speaker_posterior_segmenter regression: pass");
    end else begin
      $display("speaker_posterior_segmenter regression: fail");
    end
    $finish;
  end

endmodule

// ----- speaker_posterior_segmenter.f -----
rtl/sps_pkg.sv
rtl/sps_frame_clock.sv
rtl/sps_lane.sv
rtl/sps_merge.sv
rtl/speaker_posterior_segmenter.sv
verif/speaker_posterior_segmenter_test.sv
